@@ design/ekspwm_pkg.sv @@
`default_nettype none

package ekspwm_pkg;

   // Register and field widths fixed by the register map.
   localparam int DATA_BITS  = 16;
   localparam int INDEX_BITS = 3;
   localparam int REQ_BITS   = 8;
   localparam int RSP_BITS   = 24;

   // Register values after reset.
   localparam logic [DATA_BITS-1:0] RST_PERIOD   = 16'd39999;
   localparam logic [DATA_BITS-1:0] RST_DEBOUNCE = 16'd3999;
   localparam logic [DATA_BITS-1:0] RST_WMIN     = 16'd1999;
   localparam logic [DATA_BITS-1:0] RST_WMAX     = 16'd3999;
   localparam logic [DATA_BITS-1:0] RST_WSTEP    = 16'd100;

   typedef enum logic [INDEX_BITS-1:0] {
      REG_PWM_PERIOD   = 3'd0,
      REG_DEBOUNCE_LEN = 3'd1,
      REG_WIDTH_MIN    = 3'd2,
      REG_WIDTH_MAX    = 3'd3,
      REG_WIDTH_STEP   = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      TURN_NONE = 2'd0,
      TURN_CW   = 2'd1,
      TURN_CCW  = 2'd2
   } turn_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] pwm_period;
      logic [DATA_BITS-1:0] debounce_len;
      logic [DATA_BITS-1:0] width_min;
      logic [DATA_BITS-1:0] width_max;
      logic [DATA_BITS-1:0] width_step;
   } cfg_type;

   // Packed so that pwm_level sits in bit 0.
   typedef struct packed {
      turn_type             turn_event;
      logic [DATA_BITS-1:0] pulse_width;
      logic                 pwm_level;
   } result_type;

endpackage

`default_nettype wire

@@ design/ekspwm_core.sv @@
`default_nettype none

module ekspwm_core #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  chan_a,
   input  wire logic                  chan_b,
   input  wire ekspwm_pkg::cfg_type   cfg,
   output ekspwm_pkg::result_type     result
);
   import ekspwm_pkg::*;

   localparam int CMP_BITS = (COUNT_BITS > DATA_BITS) ? COUNT_BITS : DATA_BITS;

   logic [COUNT_BITS-1:0] period_count_ff, period_count_in;
   logic [COUNT_BITS-1:0] wait_count_ff, wait_count_in;
   logic [DATA_BITS-1:0]  width_ff, width_in;
   logic                  waiting_ff, waiting_in;
   logic                  prev_a_ff, prev_a_in;

   logic [CMP_BITS-1:0]   period_ext;
   logic [CMP_BITS-1:0]   wait_ext;
   logic [DATA_BITS:0]    narrow_floor;
   logic [DATA_BITS:0]    widen_sum;
   logic [DATA_BITS-1:0]  narrow_width;
   logic [DATA_BITS-1:0]  widen_width;
   turn_type              turn;

   assign period_ext = CMP_BITS'(period_count_ff);
   assign wait_ext   = CMP_BITS'(wait_count_ff);

   // Saturating width steps; sums carry one extra bit so they never wrap.
   assign narrow_floor = {1'b0, cfg.width_min} + {1'b0, cfg.width_step};
   assign widen_sum    = {1'b0, width_ff} + {1'b0, cfg.width_step};
   assign narrow_width = ({1'b0, width_ff} >= narrow_floor) ?
                         width_ff - cfg.width_step : cfg.width_min;
   assign widen_width  = (widen_sum <= {1'b0, cfg.width_max}) ?
                         widen_sum[DATA_BITS-1:0] : cfg.width_max;

   // Period counter wraps after the programmed last count.
   always_comb begin
      if (period_ext >= CMP_BITS'(cfg.pwm_period)) begin
         period_count_in = '0;
      end else begin
         period_count_in = period_count_ff + COUNT_BITS'(1);
      end
   end

   // Debounce wait and direction decision.
   always_comb begin
      wait_count_in = wait_count_ff;
      waiting_in    = waiting_ff;
      width_in      = width_ff;
      turn          = TURN_NONE;
      if (waiting_ff) begin
         if (wait_ext >= CMP_BITS'(cfg.debounce_len)) begin
            waiting_in = 1'b0;
            if (!chan_a) begin
               if (!chan_b) begin
                  width_in = narrow_width;
                  turn     = TURN_CCW;
               end else begin
                  width_in = widen_width;
                  turn     = TURN_CW;
               end
            end
         end else begin
            wait_count_in = wait_count_ff + COUNT_BITS'(1);
         end
      end else if (prev_a_ff && !chan_a) begin
         waiting_in    = 1'b1;
         wait_count_in = '0;
      end
      prev_a_in = chan_a;
   end

   // Level uses the state from the start of the tick, width after the update.
   always_comb begin
      result.pwm_level   = (period_ext < CMP_BITS'(width_ff));
      result.pulse_width = width_in;
      result.turn_event  = turn;
   end

   // Timer and encoder state advance once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_count_ff <= '0;
         wait_count_ff   <= '0;
         width_ff        <= RST_WMIN;
         waiting_ff      <= 1'b0;
         prev_a_ff       <= 1'b1;
      end else if (advance) begin
         period_count_ff <= period_count_in;
         wait_count_ff   <= wait_count_in;
         width_ff        <= width_in;
         waiting_ff      <= waiting_in;
         prev_a_ff       <= prev_a_in;
      end
   end

endmodule

`default_nettype wire

@@ design/encoder_knob_servo_pwm.sv @@
// Channel  Direction  Ports                         Contents
// req      in         req_tvalid/tready/tdata       one timer tick with encoder levels
// rsp      out        rsp_tvalid/tready/tdata       PWM level, pulse width, turn event
// csr      in         csr_valid/ready/index/data    register writes, always ready
//
// One tick is accepted per cycle while ready is high; each result is registered.
// All tick work is a single pass of compare and add logic ahead of the
// output register. A two-entry output buffer (output register plus skid
// register) keeps input accepted while one result waits, so ready drops only
// when both entries are full. Synchronous reset clears counters, buffers and
// restores the register defaults.
`default_nettype none

module encoder_knob_servo_pwm #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // Bit 0 chan_a, bit 1 chan_b, upper bits zero.
   input  wire logic [ekspwm_pkg::REQ_BITS-1:0]       req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // Bit 0 pwm_level, bits 16:1 pulse_width, bits 18:17 turn_event, rest zero.
   output logic [ekspwm_pkg::RSP_BITS-1:0]            rsp_tdata,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ekspwm_pkg::INDEX_BITS-1:0]     csr_index,
   input  wire logic [ekspwm_pkg::DATA_BITS-1:0]      csr_data
);
   import ekspwm_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   result_type result;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       accept;
   logic       pop;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_BITS - $bits(result_type))'(0), out_ff};

   ekspwm_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .chan_a  (req_tdata[0]),
      .chan_b  (req_tdata[1]),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // Register writes; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_PWM_PERIOD:   cfg_in.pwm_period   = csr_data;
            REG_DEBOUNCE_LEN: cfg_in.debounce_len = csr_data;
            REG_WIDTH_MIN:    cfg_in.width_min    = csr_data;
            REG_WIDTH_MAX:    cfg_in.width_max    = csr_data;
            REG_WIDTH_STEP:   cfg_in.width_step   = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Output register with a skid entry behind it.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period   <= RST_PERIOD;
         cfg_ff.debounce_len <= RST_DEBOUNCE;
         cfg_ff.width_min    <= RST_WMIN;
         cfg_ff.width_max    <= RST_WMAX;
         cfg_ff.width_step   <= RST_WSTEP;
         out_valid_ff        <= 1'b0;
         skid_valid_ff       <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payloads need no reset.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

@@ design/ekspwm_checker.sv @@
`default_nettype none

module ekspwm_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [ekspwm_pkg::RSP_BITS-1:0]     rsp_tdata
);

   // Reset leaves the result channel empty and the input open.
   assert property (@(posedge clock) reset |=> (!rsp_tvalid && req_tready))
      else $error("result channel not empty after reset");

   // Input stalls only while a result is pending at the output.
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // A stalled result holds its item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result item changed");

   // Turn event code three never appears, and padding stays zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[18:17] != 2'b11 && rsp_tdata[23:19] == 5'd0))
      else $error("invalid turn event or padding in result");

endmodule

bind encoder_knob_servo_pwm ekspwm_checker u_ekspwm_checker (.*);

`default_nettype wire

@@ test/tb_encoder_knob_servo_pwm.sv @@
module tb_encoder_knob_servo_pwm;
   timeunit 1ns;
   timeprecision 1ps;

   import ekspwm_pkg::*;

   localparam int CLOCK_HALF = 4;
   localparam int RESET_CYCLES = 9;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_TICKS = 58;
   localparam int CHOKE_CYCLES = 60;
   localparam int TAIL_CYCLES = 4;
   localparam int HOLD_CAP = 24;
   localparam int RESULT_BITS = $bits(result_type);

   // Indexes past the register map; writes to them must change nothing.
   localparam logic [INDEX_BITS-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [INDEX_BITS-1:0] REG_SPARE_LAST  = 3'd7;

   // One row of the directed table: either a register write or a tick.
   typedef struct packed {
      logic                  is_csr;
      logic [INDEX_BITS-1:0] index;
      logic [DATA_BITS-1:0]  data;
      logic                  chan_a;
      logic                  chan_b;
      logic                  has_want;
      result_type            want;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // Bit 0 chan_a, bit 1 chan_b, upper bits zero.
   logic [REQ_BITS-1:0]   req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // Bit 0 pwm_level, bits 16:1 pulse_width, bits 18:17 turn_event, rest zero.
   logic [RSP_BITS-1:0]   rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [INDEX_BITS-1:0] csr_index;
   logic [DATA_BITS-1:0]  csr_data;

   // Typed expectation that travels with the tick being offered.
   logic                  tick_has_want;
   result_type            tick_want;

   // Knob model state and its copy of the registers.
   cfg_type               knob_cfg;
   logic [15:0]           period_cnt;
   logic [15:0]           width_q;
   logic [15:0]           dwell_cnt;
   logic                  settling;
   logic                  last_a;

   result_type            pending_results[$];
   int                    mismatch_count;
   int                    ticks_sent;
   bit                    calm;
   bit                    choke_req;

   encoder_knob_servo_pwm u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // Advances the knob by one tick and returns what the block should report.
   function automatic result_type turn_knob_tick(input logic a, input logic b);
      result_type r;
      r.pwm_level = (period_cnt < width_q);
      r.turn_event = TURN_NONE;
      if (period_cnt >= knob_cfg.pwm_period) begin
         period_cnt = '0;
      end else begin
         period_cnt = period_cnt + 16'd1;
      end
      if (settling) begin
         if (dwell_cnt >= knob_cfg.debounce_len) begin
            settling = 1'b0;
            if (!a && !b) begin
               // Counterclockwise: narrow, never below the minimum.
               if (32'(width_q) >= 32'(knob_cfg.width_min) + 32'(knob_cfg.width_step)) begin
                  width_q = width_q - knob_cfg.width_step;
               end else begin
                  width_q = knob_cfg.width_min;
               end
               r.turn_event = TURN_CCW;
            end else if (!a) begin
               // Clockwise: widen, never above the maximum.
               if (32'(width_q) + 32'(knob_cfg.width_step) <= 32'(knob_cfg.width_max)) begin
                  width_q = width_q + knob_cfg.width_step;
               end else begin
                  width_q = knob_cfg.width_max;
               end
               r.turn_event = TURN_CW;
            end
         end else begin
            dwell_cnt = dwell_cnt + 16'd1;
         end
      end else if (last_a && !a) begin
         settling = 1'b1;
         dwell_cnt = '0;
      end
      last_a = a;
      r.pulse_width = width_q;
      return r;
   endfunction

   // Model update on accepted ticks and writes, and the result check.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         knob_cfg = '{RST_PERIOD, RST_DEBOUNCE, RST_WMIN, RST_WMAX, RST_WSTEP};
         period_cnt = '0;
         width_q = RST_WMIN;
         dwell_cnt = '0;
         settling = 1'b0;
         last_a = 1'b1;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[RESULT_BITS-1:0]);
            if (pending_results.size() == 0) begin
               $error("result with no tick pending: rsp_tdata %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.pwm_level !== want.pwm_level) begin
                  $error("pwm_level: expected %0d, got %0d", want.pwm_level, got.pwm_level);
                  mismatch_count++;
               end
               if (got.pulse_width !== want.pulse_width) begin
                  $error("pulse_width: expected %0d, got %0d",
                         want.pulse_width, got.pulse_width);
                  mismatch_count++;
               end
               if (got.turn_event !== want.turn_event) begin
                  $error("turn_event: expected %0d, got %0d",
                         want.turn_event, got.turn_event);
                  mismatch_count++;
               end
               if (rsp_tdata[RSP_BITS-1:RESULT_BITS] !== '0) begin
                  $error("tdata padding: expected 0, got %h",
                         rsp_tdata[RSP_BITS-1:RESULT_BITS]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = turn_knob_tick(req_tdata[0], req_tdata[1]);
            pending_results.push_back(tick_has_want ? tick_want : want);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PWM_PERIOD:   knob_cfg.pwm_period = csr_data;
               REG_DEBOUNCE_LEN: knob_cfg.debounce_len = csr_data;
               REG_WIDTH_MIN:    knob_cfg.width_min = csr_data;
               REG_WIDTH_MAX:    knob_cfg.width_max = csr_data;
               REG_WIDTH_STEP:   knob_cfg.width_step = csr_data;
               default: ;
            endcase
         end
      end
   end

   // Result side: random stall bursts, one long hold-off on request,
   // none once the run is calm.
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (choke_req) begin
            rsp_tready <= 1'b0;
            repeat (CHOKE_CYCLES) @(posedge clock);
            choke_req = 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic plan_row_type tick_row(input logic a, input logic b);
      plan_row_type row;
      row = '0;
      row.chan_a = a;
      row.chan_b = b;
      return row;
   endfunction

   function automatic plan_row_type checked_row(input logic a, input logic b, input turn_type ev,
                                                input logic [DATA_BITS-1:0] w, input logic lvl);
      plan_row_type row;
      row = tick_row(a, b);
      row.has_want = 1'b1;
      row.want.turn_event = ev;
      row.want.pulse_width = w;
      row.want.pwm_level = lvl;
      return row;
   endfunction

   function automatic plan_row_type csr_row(input logic [INDEX_BITS-1:0] idx,
                                            input logic [DATA_BITS-1:0] value);
      plan_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.index = idx;
      row.data = value;
      return row;
   endfunction

   // Offers one tick, after a random gap unless the run is calm.
   task automatic push_tick(input logic a, input logic b, input logic has_want = 1'b0,
                            input result_type want = '0);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_BITS-2){1'b0}}, b, a};
      tick_has_want <= has_want;
      tick_want <= want;
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   // Stops offering ticks and waits until every result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Leaves csr_valid high so that back-to-back writes need no gap.
   task automatic write_reg(input logic [INDEX_BITS-1:0] idx,
                            input logic [DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   initial begin
      plan_row_type plan[$];
      logic [DATA_BITS-1:0] period_v;
      logic [DATA_BITS-1:0] debounce_v;
      logic [DATA_BITS-1:0] wmin_v;
      logic [DATA_BITS-1:0] wmax_v;
      logic [DATA_BITS-1:0] step_v;
      logic dir;
      int hold;
      int phase_end;
      int pick;
      bit in_csr;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      tick_has_want <= 1'b0;
      tick_want <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      calm = 1'b0;
      choke_req = 1'b0;
      mismatch_count = 0;
      ticks_sent = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      plan = '{
         // Reset defaults: wide period, pulse at the minimum width.
         checked_row(1'b1, 1'b1, TURN_NONE, 16'd1999, 1'b1),
         checked_row(1'b1, 1'b0, TURN_NONE, 16'd1999, 1'b1),
         csr_row(REG_PWM_PERIOD, 16'd3),
         csr_row(REG_DEBOUNCE_LEN, 16'd1),
         csr_row(REG_WIDTH_MIN, 16'd2),
         csr_row(REG_WIDTH_MAX, 16'd9),
         csr_row(REG_WIDTH_STEP, 16'd4),
         csr_row(REG_SPARE_FIRST, 16'hFFFF),
         csr_row(REG_SPARE_LAST, 16'h0000),
         // Falling edge, a bounce inside the wait, then a counterclockwise detent.
         tick_row(1'b0, 1'b0),
         tick_row(1'b1, 1'b0),
         tick_row(1'b0, 1'b0),
         // Clockwise detent from above the maximum clamps to the maximum.
         tick_row(1'b1, 1'b1),
         tick_row(1'b0, 1'b1),
         tick_row(1'b0, 1'b0),
         tick_row(1'b0, 1'b1),
         // A back high when the wait ends: no step.
         tick_row(1'b1, 1'b1),
         tick_row(1'b0, 1'b0),
         tick_row(1'b0, 1'b0),
         tick_row(1'b1, 1'b0),
         // Zero period, zero debounce and crossed limits.
         csr_row(REG_PWM_PERIOD, 16'd0),
         csr_row(REG_DEBOUNCE_LEN, 16'd0),
         csr_row(REG_WIDTH_MIN, 16'd20),
         csr_row(REG_WIDTH_MAX, 16'd5),
         tick_row(1'b1, 1'b0),
         tick_row(1'b0, 1'b0),
         tick_row(1'b0, 1'b0),
         tick_row(1'b1, 1'b1),
         tick_row(1'b0, 1'b1),
         tick_row(1'b0, 1'b1),
         // Full-range limits with the largest step: swing from zero to full scale.
         csr_row(REG_WIDTH_MIN, 16'd0),
         csr_row(REG_WIDTH_MAX, 16'hFFFF),
         csr_row(REG_WIDTH_STEP, 16'hFFFF),
         tick_row(1'b1, 1'b1),
         tick_row(1'b0, 1'b0),
         tick_row(1'b0, 1'b0),
         checked_row(1'b1, 1'b1, TURN_NONE, 16'd0, 1'b0),
         checked_row(1'b0, 1'b1, TURN_NONE, 16'd0, 1'b0),
         checked_row(1'b0, 1'b1, TURN_CW, 16'hFFFF, 1'b0),
         checked_row(1'b1, 1'b0, TURN_NONE, 16'hFFFF, 1'b1)
      };

      // Directed table: writes only once all results are back.
      in_csr = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            if (!in_csr) drain_results();
            write_reg(plan[i].index, plan[i].data);
            in_csr = 1'b1;
         end else begin
            if (in_csr) csr_valid <= 1'b0;
            in_csr = 1'b0;
            push_tick(plan[i].chan_a, plan[i].chan_b, plan[i].has_want, plan[i].want);
         end
      end

      // Random phases, each with its own register setting.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_results();
         if (phase == PHASE_COUNT - 1) calm = 1'b1;
         period_v = 16'($urandom_range(0, 24));
         debounce_v = 16'($urandom_range(0, 6));
         wmin_v = 16'($urandom_range(0, 12));
         wmax_v = 16'($urandom_range(4, 30));
         step_v = 16'($urandom_range(0, 6));
         case (phase)
            1: period_v = 16'hFFFF;
            2: debounce_v = 16'hFFFF;
            3: begin
               wmin_v = 16'd0;
               wmax_v = 16'hFFFF;
               step_v = 16'hFFFF;
            end
            4: begin
               wmin_v = 16'($urandom_range(20, 40));
               wmax_v = 16'($urandom_range(0, 10));
            end
            5: period_v = 16'd1;
            7: debounce_v = 16'($urandom_range(20, 40));
            default: ;
         endcase
         write_reg(REG_PWM_PERIOD, period_v);
         write_reg(REG_DEBOUNCE_LEN, debounce_v);
         write_reg(REG_WIDTH_MIN, wmin_v);
         write_reg(REG_WIDTH_MAX, wmax_v);
         write_reg(REG_WIDTH_STEP, step_v);
         if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_SPARE_FIRST, 16'($urandom_range(0, 16'hFFFF)));
         end
         csr_valid <= 1'b0;
         // Hold the result side off long enough for the input to stall.
         if (phase == 6) choke_req = 1'b1;

         hold = (debounce_v <= 60) ? int'(debounce_v) + 1 : HOLD_CAP;
         phase_end = ticks_sent + PHASE_TICKS;
         while (ticks_sent < phase_end) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
               // Clean detent: A high, falls, stays low through the wait (HOLD_CAP ticks if debounce > 60).
               repeat ($urandom_range(1, 3)) push_tick(1'b1, 1'($urandom_range(0, 1)));
               push_tick(1'b0, 1'($urandom_range(0, 1)));
               dir = 1'($urandom_range(0, 1));
               for (int k = 0; k < hold; k++) begin
                  push_tick(1'b0, (k == hold - 1) ? dir : logic'($urandom_range(0, 1)));
               end
            end else if (pick <= 8) begin
               // Contact bounce after the falling edge.
               push_tick(1'b1, 1'($urandom_range(0, 1)));
               push_tick(1'b0, 1'($urandom_range(0, 1)));
               repeat ($urandom_range(1, 6)) begin
                  push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               end
            end else begin
               repeat ($urandom_range(1, 6)) begin
                  push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               end
            end
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/ekspwm_pkg.sv
design/ekspwm_core.sv
design/encoder_knob_servo_pwm.sv
design/ekspwm_checker.sv
test/tb_encoder_knob_servo_pwm.sv
